>>> rtl/scale_tare_stable_detector_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scale tare and stability detector
// Concurrent assertion wrappers; they compile to nothing under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SCALE_TARE_STABLE_DETECTOR_CORE_MACROS_SVH
`define SCALE_TARE_STABLE_DETECTOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Implication checked on every rising clock edge outside reset.
`define STSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Plain property checked on every rising clock edge outside reset.
`define STSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`else
`define STSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define STSD_ASSERT(lbl, clk, rst_n, prop, msg)
`endif

`endif

>>> rtl/stsd_pkg.sv
// ----------------------------------------------------------------------------
// Scale tare and stability detector package
// Widths, register indexes, status codes and the state and result records.
// ----------------------------------------------------------------------------
package stsd_pkg;

  // Weight and counter widths.
  localparam int SAMPLE_BITS  = 12;
  localparam int COUNT_BITS   = 8;
  localparam int TIME_BITS    = 32;

  // Register widths.
  localparam int LIMIT_BITS    = 12;
  localparam int NEEDED_BITS   = 8;
  localparam int MINW_BITS     = 12;
  localparam int DEBOUNCE_BITS = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  // Compare widths wide enough for both operands.
  localparam int WGT_CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;
  localparam int CNT_CMP_BITS = (COUNT_BITS > NEEDED_BITS) ? COUNT_BITS : NEEDED_BITS;

  // Register reset values.
  localparam logic [LIMIT_BITS-1:0]    STABLE_LIMIT_RST  = LIMIT_BITS'(7);
  localparam logic [NEEDED_BITS-1:0]   STABLE_NEEDED_RST = NEEDED_BITS'(20);
  localparam logic [MINW_BITS-1:0]     MIN_WEIGHT_RST    = MINW_BITS'(1);
  localparam logic [DEBOUNCE_BITS-1:0] PRESS_GAP_RST     = DEBOUNCE_BITS'(300);

  // Register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STABLE_LIMIT  = 2'd0,
    CFG_STABLE_NEEDED = 2'd1,
    CFG_MIN_WEIGHT    = 2'd2,
    CFG_PRESS_GAP     = 2'd3
  } cfg_reg_e;

  // Display status codes.
  typedef enum logic [1:0] {
    ST_SENT       = 2'd0,
    ST_PUBLISHING = 2'd1,
    ST_PLACE_ITEM = 2'd2,
    ST_DETECTING  = 2'd3
  } status_e;

  typedef struct packed {
    logic [LIMIT_BITS-1:0]    stable_limit;
    logic [NEEDED_BITS-1:0]   stable_needed;
    logic [MINW_BITS-1:0]     min_weight;
    logic [DEBOUNCE_BITS-1:0] press_gap;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] tare;
    logic                   tare_loaded;
    logic [SAMPLE_BITS-1:0] prev_net;
    logic                   prev_valid;
    logic [COUNT_BITS-1:0]  count;
    logic                   published;
    logic                   last_button;
    logic [TIME_BITS-1:0]   last_press_ms;
  } state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] net_weight;
    logic [SAMPLE_BITS-1:0] tare_value;
    logic [COUNT_BITS-1:0]  stable_run;
    logic                   publish_now;
    logic                   sent_flag;
    logic                   tare_taken;
    status_e                status;
  } result_t;

endpackage

>>> rtl/stsd_step.sv
// ----------------------------------------------------------------------------
// Scale tare and stability detector step logic
// Combinational update of the detector state and the result for one item.
// ----------------------------------------------------------------------------
module stsd_step (
  input  logic [stsd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                             button_level_i,
  input  logic [stsd_pkg::TIME_BITS-1:0]   now_ms_i,
  input  stsd_pkg::cfg_t                   cfg_i,
  input  stsd_pkg::state_t                 state_i,
  output stsd_pkg::state_t                 state_o,
  output stsd_pkg::result_t                result_o
);

  localparam logic [stsd_pkg::COUNT_BITS-1:0] CountMax = '1;

  logic [stsd_pkg::SAMPLE_BITS-1:0] tare_eff;
  logic [stsd_pkg::SAMPLE_BITS-1:0] net;
  logic [stsd_pkg::SAMPLE_BITS-1:0] diff;
  logic [stsd_pkg::TIME_BITS-1:0]   elapsed;
  logic                             press;
  logic                             stable;
  logic                             above_min;
  logic                             below_min;
  logic                             target_met;
  logic                             pulse;
  logic [stsd_pkg::COUNT_BITS-1:0]  cnt0;
  logic [stsd_pkg::COUNT_BITS-1:0]  cnt1;
  logic [stsd_pkg::COUNT_BITS-1:0]  cnt2;
  logic                             pub0;
  logic                             pub1;
  logic                             pub2;

  // The very first item takes its own sample as tare.
  assign tare_eff = state_i.tare_loaded ? state_i.tare : sample_i;
  assign net      = (sample_i > tare_eff) ? (sample_i - tare_eff) : '0;

  // Debounced falling edge of the tare button; elapsed time wraps.
  assign elapsed = now_ms_i - state_i.last_press_ms;
  assign press   = !button_level_i && state_i.last_button &&
                   (elapsed > stsd_pkg::TIME_BITS'(cfg_i.press_gap));

  assign cnt0 = press ? '0 : state_i.count;
  assign pub0 = press ? 1'b0 : state_i.published;

  // Stability compare against the previous net, saturating count.
  assign diff   = (net > state_i.prev_net) ? (net - state_i.prev_net)
                                           : (state_i.prev_net - net);
  assign stable = state_i.prev_valid &&
                  (stsd_pkg::WGT_CMP_BITS'(diff) <
                   stsd_pkg::WGT_CMP_BITS'(cfg_i.stable_limit));
  assign cnt1   = !stable ? '0 :
                  (cnt0 == CountMax) ? cnt0 : cnt0 + stsd_pkg::COUNT_BITS'(1);
  assign pub1   = stable ? pub0 : 1'b0;

  // Publish decision.
  assign above_min  = stsd_pkg::WGT_CMP_BITS'(net) >
                      stsd_pkg::WGT_CMP_BITS'(cfg_i.min_weight);
  assign below_min  = stsd_pkg::WGT_CMP_BITS'(net) <
                      stsd_pkg::WGT_CMP_BITS'(cfg_i.min_weight);
  assign pulse      = (stsd_pkg::CNT_CMP_BITS'(cnt1) >=
                       stsd_pkg::CNT_CMP_BITS'(cfg_i.stable_needed)) &&
                      above_min && !pub1;
  assign pub2       = pub1 || pulse;
  assign cnt2       = pulse ? '0 : cnt1;
  assign target_met = stsd_pkg::CNT_CMP_BITS'(cnt2) >=
                      stsd_pkg::CNT_CMP_BITS'(cfg_i.stable_needed);

  // Next state.
  always_comb begin
    state_o               = state_i;
    state_o.tare          = press ? sample_i : tare_eff;
    state_o.tare_loaded   = 1'b1;
    state_o.prev_net      = net;
    state_o.prev_valid    = 1'b1;
    state_o.count         = cnt2;
    state_o.published     = pub2;
    state_o.last_button   = button_level_i;
    state_o.last_press_ms = press ? now_ms_i : state_i.last_press_ms;
  end

  // Result for this item, status in priority order.
  always_comb begin
    result_o             = '0;
    result_o.net_weight  = net;
    result_o.tare_value  = press ? sample_i : tare_eff;
    result_o.stable_run  = cnt2;
    result_o.publish_now = pulse;
    result_o.sent_flag   = pub2;
    result_o.tare_taken  = press;
    if (pub2 && above_min) begin
      result_o.status = stsd_pkg::ST_SENT;
    end else if (target_met) begin
      result_o.status = stsd_pkg::ST_PUBLISHING;
    end else if (below_min) begin
      result_o.status = stsd_pkg::ST_PLACE_ITEM;
    end else begin
      result_o.status = stsd_pkg::ST_DETECTING;
    end
  end

endmodule

>>> rtl/scale_tare_stable_detector_core.sv
// ----------------------------------------------------------------------------
// Scale tare and stability detector
// Tare capture, debounced re-tare, net weight, stability count and publish.
// ----------------------------------------------------------------------------
// A result passes from the input register through the combinational step
// logic into the result register.
// One item per cycle while the result register is not held by out_stall_i.
// Reset clears the handshake, loads the register defaults and returns the
// detector to its untared state with the button taken as released.
`include "scale_tare_stable_detector_core_macros.svh"

module scale_tare_stable_detector_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [stsd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [stsd_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  // Input channel.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [stsd_pkg::SAMPLE_BITS-1:0]    sample_i,
  input  logic                                button_level_i,
  input  logic [stsd_pkg::TIME_BITS-1:0]      now_ms_i,
  // Output channel.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [stsd_pkg::SAMPLE_BITS-1:0]    net_weight_o,
  output logic [stsd_pkg::SAMPLE_BITS-1:0]    tare_value_o,
  output logic [stsd_pkg::COUNT_BITS-1:0]     stable_run_o,
  output logic                                publish_now_o,
  output logic                                sent_flag_o,
  output logic                                tare_taken_o,
  output logic [1:0]                          status_code_o
);

  stsd_pkg::cfg_t                   cfg_q;
  stsd_pkg::state_t                 state_q;
  stsd_pkg::state_t                 state_d;
  stsd_pkg::result_t                result_d;
  stsd_pkg::result_t                result_q;
  logic                             in_valid_q;
  logic [stsd_pkg::SAMPLE_BITS-1:0] sample_q;
  logic                             button_q;
  logic [stsd_pkg::TIME_BITS-1:0]   now_q;
  logic                             out_valid_q;
  logic                             out_free;
  logic                             step_go;
  logic                             in_take;

  // Pipeline control: the result register frees when empty or taken.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step_go    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stable_limit  <= stsd_pkg::STABLE_LIMIT_RST;
      cfg_q.stable_needed <= stsd_pkg::STABLE_NEEDED_RST;
      cfg_q.min_weight    <= stsd_pkg::MIN_WEIGHT_RST;
      cfg_q.press_gap     <= stsd_pkg::PRESS_GAP_RST;
    end else if (cfg_we_i) begin
      case (stsd_pkg::cfg_reg_e'(cfg_index_i))
        stsd_pkg::CFG_STABLE_LIMIT: begin
          cfg_q.stable_limit <= cfg_data_i[stsd_pkg::LIMIT_BITS-1:0];
        end
        stsd_pkg::CFG_STABLE_NEEDED: begin
          cfg_q.stable_needed <= cfg_data_i[stsd_pkg::NEEDED_BITS-1:0];
        end
        stsd_pkg::CFG_MIN_WEIGHT: begin
          cfg_q.min_weight <= cfg_data_i[stsd_pkg::MINW_BITS-1:0];
        end
        stsd_pkg::CFG_PRESS_GAP: begin
          cfg_q.press_gap <= cfg_data_i[stsd_pkg::DEBOUNCE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (step_go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= sample_i;
      button_q <= button_level_i;
      now_q    <= now_ms_i;
    end
  end

  // Step logic for the item in the input register.
  stsd_step u_step (
    .sample_i       (sample_q),
    .button_level_i (button_q),
    .now_ms_i       (now_q),
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  // Detector state advances once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.tare          <= '0;
      state_q.tare_loaded   <= 1'b0;
      state_q.prev_net      <= '0;
      state_q.prev_valid    <= 1'b0;
      state_q.count         <= '0;
      state_q.published     <= 1'b0;
      state_q.last_button   <= 1'b1;
      state_q.last_press_ms <= '0;
    end else if (step_go) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign net_weight_o  = result_q.net_weight;
  assign tare_value_o  = result_q.tare_value;
  assign stable_run_o  = result_q.stable_run;
  assign publish_now_o = result_q.publish_now;
  assign sent_flag_o   = result_q.sent_flag;
  assign tare_taken_o  = result_q.tare_taken;
  assign status_code_o = result_q.status;

  // A publish pulse sets the flag and restarts the count.
  `STSD_ASSERT_IMP(a_pulse_sets_flag, clk_i, rst_ni, out_valid_q && result_q.publish_now, result_q.sent_flag && (result_q.stable_run == '0), "publish without flag set and count cleared")
  // The sent status is only shown once the weight has been published.
  `STSD_ASSERT_IMP(a_sent_status, clk_i, rst_ni, out_valid_q && (result_q.status == stsd_pkg::ST_SENT), result_q.sent_flag, "sent status without published flag")
  // The input side stalls only behind a held, stalled result.
  `STSD_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, in_valid_q && out_valid_q && out_stall_i, "input stall without a blocked result")
  // After the first processed item the tare is always loaded.
  `STSD_ASSERT_IMP(a_tare_loaded, clk_i, rst_ni, $past(step_go), state_q.tare_loaded && state_q.prev_valid, "tare not loaded after an item")

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the scale tare and stability detector
// Drives sample ticks with random gaps and back-pressure, predicts every
// reading in a scoreboard of its own and compares the readings field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import stsd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 4;

  // Scoreboard: mirrors the tare and stability state and holds the readings
  // still to come out of the block.
  class scale_checker;
    cfg_t    settings;
    state_t  st;
    result_t pending_readings[$];
    int      mismatch_count;

    function new();
      settings.stable_limit  = STABLE_LIMIT_RST;
      settings.stable_needed = STABLE_NEEDED_RST;
      settings.min_weight    = MIN_WEIGHT_RST;
      settings.press_gap     = PRESS_GAP_RST;
      st             = '0;
      st.last_button = 1'b1;
      mismatch_count = 0;
    endfunction

    // Only the low bits of the write data belong to each register.
    function void write_register(cfg_reg_e idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_STABLE_LIMIT:  settings.stable_limit  = data[LIMIT_BITS-1:0];
        CFG_STABLE_NEEDED: settings.stable_needed = data[NEEDED_BITS-1:0];
        CFG_MIN_WEIGHT:    settings.min_weight    = data[MINW_BITS-1:0];
        CFG_PRESS_GAP:     settings.press_gap     = data[DEBOUNCE_BITS-1:0];
        default: ;
      endcase
    endfunction

    // Works out the reading that one accepted sample tick produces.
    function void predict_tick(logic [SAMPLE_BITS-1:0] smp, logic btn,
                               logic [TIME_BITS-1:0] now);
      result_t                want;
      logic [SAMPLE_BITS-1:0] net;
      logic [SAMPLE_BITS-1:0] delta;
      logic [TIME_BITS-1:0]   elapsed;
      logic                   pulse;
      logic                   took;

      // The very first tick after reset becomes the tare.
      if (!st.tare_loaded) begin
        st.tare        = smp;
        st.tare_loaded = 1'b1;
      end
      net = (smp > st.tare) ? smp - st.tare : '0;

      // A debounced falling edge re-tares; this tick's net keeps the old tare.
      took    = 1'b0;
      elapsed = now - st.last_press_ms;
      if (!btn && st.last_button && elapsed > TIME_BITS'(settings.press_gap)) begin
        st.last_press_ms = now;
        st.tare          = smp;
        st.count         = '0;
        st.published     = 1'b0;
        took             = 1'b1;
      end
      st.last_button = btn;

      // Stability count saturates; any unstable step clears it and the flag.
      delta = (net > st.prev_net) ? net - st.prev_net : st.prev_net - net;
      if (st.prev_valid && WGT_CMP_BITS'(delta) < WGT_CMP_BITS'(settings.stable_limit)) begin
        if (st.count != '1) st.count = st.count + 1'b1;
      end else begin
        st.count     = '0;
        st.published = 1'b0;
      end
      st.prev_net   = net;
      st.prev_valid = 1'b1;

      pulse = 1'b0;
      if (CNT_CMP_BITS'(st.count) >= CNT_CMP_BITS'(settings.stable_needed) &&
          net > settings.min_weight && !st.published) begin
        pulse        = 1'b1;
        st.published = 1'b1;
        st.count     = '0;
      end

      // Display status, taken after the publish decision.
      if (st.published && net > settings.min_weight) begin
        want.status = ST_SENT;
      end else if (CNT_CMP_BITS'(st.count) >= CNT_CMP_BITS'(settings.stable_needed)) begin
        want.status = ST_PUBLISHING;
      end else if (net < settings.min_weight) begin
        want.status = ST_PLACE_ITEM;
      end else begin
        want.status = ST_DETECTING;
      end

      want.net_weight  = net;
      want.tare_value  = st.tare;
      want.stable_run  = st.count;
      want.publish_now = pulse;
      want.sent_flag   = st.published;
      want.tare_taken  = took;
      pending_readings.push_back(want);
    endfunction

    function void note_failure(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Compares one reading from the block with the oldest prediction.
    function void check_reading(result_t got);
      result_t want;
      if (pending_readings.size() == 0) begin
        note_failure($sformatf("reading with none expected, net %0d tare %0d",
                               got.net_weight, got.tare_value));
        return;
      end
      want = pending_readings.pop_front();
      if (got.net_weight !== want.net_weight || got.tare_value !== want.tare_value ||
          got.stable_run !== want.stable_run || got.publish_now !== want.publish_now ||
          got.sent_flag !== want.sent_flag || got.tare_taken !== want.tare_taken ||
          got.status !== want.status) begin
        note_failure($sformatf({"expected net %0d tare %0d run %0d pub %0b sent %0b ",
                                "took %0b status %0d; got net %0d tare %0d run %0d ",
                                "pub %0b sent %0b took %0b status %0d"},
                               want.net_weight, want.tare_value, want.stable_run,
                               want.publish_now, want.sent_flag, want.tare_taken,
                               want.status, got.net_weight, got.tare_value,
                               got.stable_run, got.publish_now, got.sent_flag,
                               got.tare_taken, got.status));
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_STABLE_LIMIT;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [SAMPLE_BITS-1:0]   sample = '0;
  logic                     button_level = 1'b1;
  logic [TIME_BITS-1:0]     now_ms = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [SAMPLE_BITS-1:0]   net_weight;
  logic [SAMPLE_BITS-1:0]   tare_value;
  logic [COUNT_BITS-1:0]    stable_run;
  logic                     publish_now;
  logic                     sent_flag;
  logic                     tare_taken;
  logic [1:0]               status_code;

  scale_checker sb = new();
  bit           no_idle = 1'b0;
  int           cycle_count = 0;
  int           load_level = 0;
  int           press_left = 0;
  logic [TIME_BITS-1:0] clock_ms = '0;

  scale_tare_stable_detector_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .button_level_i (button_level),
    .now_ms_i       (now_ms),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .net_weight_o   (net_weight),
    .tare_value_o   (tare_value),
    .stable_run_o   (stable_run),
    .publish_now_o  (publish_now),
    .sent_flag_o    (sent_flag),
    .tare_taken_o   (tare_taken),
    .status_code_o  (status_code)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Every accepted reading is checked against the scoreboard.
  always @(posedge clk) begin : reading_monitor
    result_t got;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got.net_weight  = net_weight;
      got.tare_value  = tare_value;
      got.stable_run  = stable_run;
      got.publish_now = publish_now;
      got.sent_flag   = sent_flag;
      got.tare_taken  = tare_taken;
      got.status      = status_e'(status_code);
      sb.check_reading(got);
    end
  end

  // Reading side: stalls for a random number of cycles before each item.
  initial begin : reading_sink
    int hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid === 1'b1 && !out_stall));
    end
  end

  // Presents one sample tick after a random gap and waits until it is taken.
  task automatic send_tick(input logic [SAMPLE_BITS-1:0] smp, input logic btn,
                           input logic [TIME_BITS-1:0] now);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample       <= smp;
    button_level <= btn;
    now_ms       <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.predict_tick(smp, btn, now);
  endtask

  // A tick from a plausible scale: a load with jitter, short button presses
  // and a rising clock, with the odd fully random tick mixed in.
  task automatic send_random_tick(input int amp, input bit calm);
    int   jit;
    int   lvl;
    logic btn;
    if (!calm && $urandom_range(0, 19) == 0) begin
      send_tick(SAMPLE_BITS'($urandom), 1'($urandom), $urandom);
      return;
    end
    if ($urandom_range(0, 39) == 0) load_level = $urandom_range(0, 4095);
    jit = int'($urandom_range(0, 2 * amp)) - amp;
    lvl = load_level + jit;
    if (lvl < 0) lvl = 0;
    if (lvl > 4095) lvl = 4095;
    if (calm) begin
      btn = 1'b1;
    end else if (press_left > 0) begin
      btn = 1'b0;
      press_left--;
    end else begin
      btn = 1'b1;
      if ($urandom_range(0, 24) == 0) press_left = $urandom_range(1, 3);
    end
    if (calm || $urandom_range(0, 49) != 0) begin
      clock_ms = clock_ms + $urandom_range(1, 250);
    end else begin
      clock_ms = clock_ms + $urandom;
    end
    send_tick(SAMPLE_BITS'(lvl), btn, clock_ms);
  endtask

  // Lets the pipeline empty so that registers may be written.
  task automatic drain;
    in_valid <= 1'b0;
    while (sb.pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Sets random bits above a register's width, which the block must ignore.
  function automatic logic [CFG_DATA_BITS-1:0] pad_high(logic [CFG_DATA_BITS-1:0] v, int w);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = CFG_DATA_BITS'($urandom);
    return (junk << w) | (v & ((CFG_DATA_BITS'(1) << w) - 1'b1));
  endfunction

  task automatic put_register(input cfg_reg_e idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_register(idx, data);
    @(posedge clk);
  endtask

  task automatic load_settings(input int lim, input int need, input int minw, input int deb);
    put_register(CFG_STABLE_LIMIT, pad_high(CFG_DATA_BITS'(lim), LIMIT_BITS));
    put_register(CFG_STABLE_NEEDED, pad_high(CFG_DATA_BITS'(need), NEEDED_BITS));
    put_register(CFG_MIN_WEIGHT, pad_high(CFG_DATA_BITS'(minw), MINW_BITS));
    put_register(CFG_PRESS_GAP, CFG_DATA_BITS'(deb));
    cfg_we <= 1'b0;
  endtask

  // Main sequence: reset, directed ticks at the reset settings, then random
  // phases under a range of settings.
  initial begin : stimulus
    int lim;
    int need;
    int minw;
    int deb;
    int amp;
    int n_items;
    bit calm;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First tick takes full scale as tare, then net clamps at zero.
    send_tick(12'd4095, 1'b1, 32'd0);
    send_tick(12'd0, 1'b1, 32'd10);
    send_tick(12'd4095, 1'b1, 32'd20);
    // Press exactly at the debounce time is refused, one later is taken.
    send_tick(12'd0, 1'b0, 32'd300);
    send_tick(12'd0, 1'b1, 32'd301);
    send_tick(12'd100, 1'b0, 32'd301);
    send_tick(12'd100, 1'b1, 32'd400);
    send_tick(12'd2000, 1'b0, 32'd601);
    send_tick(12'd2000, 1'b1, 32'd602);
    send_tick(12'd2000, 1'b0, 32'd602);
    // A held button gives no new falling edge.
    send_tick(12'd2000, 1'b0, 32'd5000);
    send_tick(12'd2001, 1'b1, 32'd5001);
    send_tick(12'd2000, 1'b1, 32'd5002);
    // Elapsed time across the wrap of the millisecond clock.
    send_tick(12'd3000, 1'b0, 32'hFFFF_FFF0);
    send_tick(12'd3001, 1'b1, 32'hFFFF_FFFF);
    send_tick(12'd3002, 1'b0, 32'h0000_0100);
    send_tick(12'd3003, 1'b1, 32'h0000_0150);
    send_tick(12'd3004, 1'b0, 32'h0000_0200);
    send_tick(12'd4095, 1'b1, 32'hAAAA_5555);
    send_tick(12'd0, 1'b1, 32'h5555_AAAA);

    clock_ms   = $urandom;
    load_level = $urandom_range(0, 4095);
    for (int p = 0; p < 9; p++) begin
      drain();
      calm    = 1'b0;
      n_items = 130;
      amp     = $urandom_range(0, 4);
      case (p)
        0: begin
          lim = 0; need = 0; minw = 0; deb = 0;
        end
        1: begin
          // Long quiet run: the count saturates since nothing can publish.
          lim = 4095; need = 255; minw = 4095; deb = 65535;
          calm = 1'b1; n_items = 300;
        end
        2: begin
          lim = STABLE_LIMIT_RST; need = STABLE_NEEDED_RST;
          minw = MIN_WEIGHT_RST; deb = PRESS_GAP_RST;
        end
        4: begin
          lim = 4095; need = 1; minw = 0; deb = 0;
        end
        default: begin
          lim  = $urandom_range(1, 40);
          need = $urandom_range(0, 12);
          minw = $urandom_range(0, 300);
          deb  = $urandom_range(0, 2000);
        end
      endcase
      if (p == 5) clock_ms = 32'hFFFF_F000;
      load_settings(lim, need, minw, deb);
      no_idle = (p == 2 || p == 6);
      for (int i = 0; i < n_items; i++) send_random_tick(amp, calm);
    end

    drain();
    if (sb.mismatch_count == 0 && sb.pending_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
